### rtl/core/cot_pkg.sv
package cot_pkg;

  localparam int unsigned DEPTH_DEF        = 1024;
  localparam int unsigned HEADER_BYTES_DEF = 12;

  typedef enum logic [1:0] {
    OP_APPEND   = 2'd0,
    OP_READ     = 2'd1,
    OP_RELOCATE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_BAD  = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_RESP
  } state_t;

  typedef struct packed {
    logic    latch;
    logic    append;
    logic    rd_issue;
    logic    walk_start;
    logic    walk_step;
    logic    set_status;
    status_t status;
    logic    load_out;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic full;
    logic bad_index;
    logic bad_range;
    logic empty;
    logic walk_done;
  } stat_t;

endpackage

### rtl/core/cot_ctrl.sv
module cot_ctrl
  import cot_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  output logic  busy,
  output logic  out_valid,
  input  stat_t st,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    cmd           = '0;
    cmd.status    = ST_OK;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.set_status = 1'b1;
        state_nxt      = S_RESP;
        unique case (st.op)
          OP_APPEND: begin
            if (st.full) begin
              cmd.status = ST_FULL;
            end else begin
              cmd.append = 1'b1;
            end
          end
          OP_READ: begin
            if (st.bad_index) begin
              cmd.status = ST_BAD;
            end else begin
              cmd.rd_issue = 1'b1;
            end
          end
          OP_RELOCATE: begin
            if (st.bad_range) begin
              cmd.status = ST_BAD;
            end else if (!st.empty) begin
              cmd.walk_start = 1'b1;
              state_nxt      = S_WALK;
            end
          end
          default: begin
            cmd.status = ST_BAD;
          end
        endcase
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        if (st.walk_done) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        cmd.load_out  = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

### rtl/core/cot_dp.sv
module cot_dp
  import cot_pkg::*;
#(
  parameter int unsigned DEPTH        = DEPTH_DEF,
  parameter int unsigned HEADER_BYTES = HEADER_BYTES_DEF,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1),
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned BB_W  = $clog2(HEADER_BYTES + 4 + 8 * DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cmd_t                cmd,
  output stat_t               st,
  input  logic [1:0]          in_operation,
  input  logic [63:0]         in_offset_value,
  input  logic [CNT_W-1:0]    in_first_index,
  input  logic [CNT_W-1:0]    in_last_index,
  input  logic [63:0]         in_range_base,
  input  logic [63:0]         in_range_end,
  input  logic signed [31:0]  in_shift_amount,
  output logic [63:0]         out_read_offset,
  output logic [1:0]          out_status,
  output logic [CNT_W-1:0]    out_entry_count,
  output logic                out_needs_large,
  output logic [BB_W-1:0]     out_box_bytes
);

  logic [63:0] mem [DEPTH];

  op_t                op_r;
  logic [63:0]        val_r;
  logic [CNT_W-1:0]   first_r, last_r;
  logic [63:0]        base_r, end_r;
  logic signed [31:0] shift_r;
  status_t            status_r;

  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   large_r, large_nxt;
  logic [CNT_W-1:0]   ptr_r, ptr_nxt;
  logic [AW-1:0]      wa_r;
  logic               pend_r, pend_nxt;
  logic [63:0]        rdata_r;

  logic [63:0]        rd_offset_r;
  logic [1:0]         out_status_r;
  logic [CNT_W-1:0]   out_count_r;
  logic               out_large_r;
  logic [BB_W-1:0]    out_bytes_r;

  logic               first_ok, last_ok, issue_ok, in_win;
  logic [63:0]        new_val;
  logic               mem_we;
  logic [AW-1:0]      mem_wa, mem_ra;
  logic [63:0]        mem_wd;
  logic [CNT_W-1:0]   first_m1;
  logic [BB_W-1:0]    per_bytes;

  assign first_ok = (first_r != '0) && (first_r <= count_r);
  assign last_ok  = (last_r != '0) && (last_r <= count_r);
  assign first_m1 = first_r - CNT_W'(1);
  assign issue_ok = (ptr_r < last_r);

  assign st.op        = op_r;
  assign st.full      = (count_r == CNT_W'(DEPTH));
  assign st.bad_index = !first_ok;
  assign st.bad_range = !first_ok || !last_ok;
  assign st.empty     = (first_r > last_r);
  assign st.walk_done = !issue_ok;

  assign in_win  = (rdata_r >= base_r) && (rdata_r < end_r);
  assign new_val = rdata_r + {{32{shift_r[31]}}, shift_r};

  always_comb begin
    mem_we    = 1'b0;
    mem_wa    = wa_r;
    mem_wd    = new_val;
    mem_ra    = ptr_r[AW-1:0];
    count_nxt = count_r;
    large_nxt = large_r;
    ptr_nxt   = ptr_r;
    pend_nxt  = pend_r;
    if (cmd.append) begin
      mem_we    = 1'b1;
      mem_wa    = count_r[AW-1:0];
      mem_wd    = val_r;
      count_nxt = count_r + CNT_W'(1);
      if (val_r[63:32] != '0) begin
        large_nxt = large_r + CNT_W'(1);
      end
    end
    if (cmd.rd_issue) begin
      mem_ra = first_m1[AW-1:0];
    end
    if (cmd.walk_start) begin
      ptr_nxt  = first_m1;
      pend_nxt = 1'b0;
    end
    if (cmd.walk_step) begin
      pend_nxt = issue_ok;
      if (issue_ok) begin
        ptr_nxt = ptr_r + CNT_W'(1);
      end
      if (pend_r && in_win) begin
        mem_we    = 1'b1;
        large_nxt = large_r - CNT_W'(rdata_r[63:32] != '0)
                    + CNT_W'(new_val[63:32] != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      large_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      large_r <= large_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    wa_r  <= ptr_r[AW-1:0];
    if (cmd.latch) begin
      op_r    <= op_t'(in_operation);
      val_r   <= in_offset_value;
      first_r <= in_first_index;
      last_r  <= in_last_index;
      base_r  <= in_range_base;
      end_r   <= in_range_end;
      shift_r <= in_shift_amount;
    end
    if (cmd.set_status) begin
      status_r <= cmd.status;
    end
  end

  assign per_bytes = (large_r != '0) ? (BB_W'(count_r) << 3) : (BB_W'(count_r) << 2);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rd_offset_r  <= (op_r == OP_READ && status_r == ST_OK) ? rdata_r : '0;
      out_status_r <= status_r;
      out_count_r  <= count_r;
      out_large_r  <= (large_r != '0);
      out_bytes_r  <= BB_W'(HEADER_BYTES + 4) + per_bytes;
    end
  end

  assign out_read_offset = rd_offset_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_count_r;
  assign out_needs_large = out_large_r;
  assign out_box_bytes   = out_bytes_r;

endmodule

### rtl/core/chunk_offset_table.sv
// Chunk offset table with a start/busy command input and a one-cycle out_valid
// strobe; the receiver cannot stall, so out_valid holds for exactly one cycle
// and must be captured then. An item is taken when start is high and busy is
// low. Append, read, a rejected item and an empty relocate pass through the
// execute and response states, with the result strobed in the first cycle
// that busy is low again. A relocate over a nonempty range also walks the
// entries in a walk state: it reads one entry and writes back the previous
// one when its offset lies within the range, each cycle through the
// single-read, single-write offset memory. The offset memory needs no clearing after reset.
module chunk_offset_table
  import cot_pkg::*;
#(
  parameter int unsigned DEPTH        = DEPTH_DEF,
  parameter int unsigned HEADER_BYTES = HEADER_BYTES_DEF,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1),
  localparam int unsigned BB_W  = $clog2(HEADER_BYTES + 4 + 8 * DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_operation,
  input  logic [63:0]        in_offset_value,
  input  logic [CNT_W-1:0]   in_first_index,
  input  logic [CNT_W-1:0]   in_last_index,
  input  logic [63:0]        in_range_base,
  input  logic [63:0]        in_range_end,
  input  logic signed [31:0] in_shift_amount,
  output logic               out_valid,
  output logic [63:0]        out_read_offset,
  output logic [1:0]         out_status,
  output logic [CNT_W-1:0]   out_entry_count,
  output logic               out_needs_large,
  output logic [BB_W-1:0]    out_box_bytes
);

  cmd_t  cmd;
  stat_t st;

  cot_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .st        (st),
    .cmd       (cmd)
  );

  cot_dp #(
    .DEPTH        (DEPTH),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .st              (st),
    .in_operation    (in_operation),
    .in_offset_value (in_offset_value),
    .in_first_index  (in_first_index),
    .in_last_index   (in_last_index),
    .in_range_base   (in_range_base),
    .in_range_end    (in_range_end),
    .in_shift_amount (in_shift_amount),
    .out_read_offset (out_read_offset),
    .out_status      (out_status),
    .out_entry_count (out_entry_count),
    .out_needs_large (out_needs_large),
    .out_box_bytes   (out_box_bytes)
  );

endmodule
